>>> design/s2c_pkg.sv
// Shared types and constants for the seconds-to-calendar-date converter.
`default_nettype none

package s2c_pkg;

  localparam int NCELL      = 27;  // length of the cell chain
  localparam int HOUR_START = 16;  // first cell of the hour / four-year split
  localparam int MIN_START  = 21;  // first cell of the minute split

  // One division lane: working remainder and the quotient built so far.
  typedef struct packed {
    logic [31:0] num;
    logic [15:0] quo;
  } lane_t;

  // Results already settled, carried down the chain beside the lanes.
  typedef struct packed {
    logic       ovf;
    logic [4:0] hour;
    logic [6:0] yr;
    logic       leap;
    logic [8:0] yday;
  } side_t;

  // Everything one cell holds for one word.
  typedef struct packed {
    lane_t l0;
    lane_t l1;
    side_t side;
  } word_t;

endpackage

`default_nettype wire

>>> design/s2c_cell.sv
// One cell of the chain: a restoring division step on each of two lanes.
`default_nettype none

module s2c_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  s2c_pkg::word_t  in_word,
  input  logic [31:0]     den0,
  input  logic [31:0]     den1,
  output logic            out_valid,
  output s2c_pkg::word_t  out_word
);
  import s2c_pkg::*;

  logic  valid_r;
  word_t word_r;
  word_t word_nxt;

  function automatic lane_t div_step(input lane_t l, input logic [31:0] d);
    lane_t o;
    if (l.num >= d) begin
      o.num = l.num - d;
      o.quo = {l.quo[14:0], 1'b1};
    end else begin
      o.num = l.num;
      o.quo = {l.quo[14:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    word_nxt.l0   = div_step(in_word.l0, den0);
    word_nxt.l1   = div_step(in_word.l1, den1);
    word_nxt.side = in_word.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

>>> design/seconds_to_calendar_date_core.sv
// Top level of the seconds-to-calendar-date converter: cell chain and output register.
`default_nettype none

// Converts a count of seconds since 2000-01-01 00:00:00 into year offset, month, day, hour,
// minute and second for the years 2000 to 2099; a count of 0xBC191380 or more gives
// 2000-01-01 00:00:00. The work runs down a chain of 27 division cells (16 for the day
// count, 5 for hour and four-year block, 6 for minute) followed by the output register, and
// a new word can be taken every cycle while the output is not stalled. The chain moves as
// one: while a finished word waits on the output, nothing in the chain advances.
module seconds_to_calendar_date_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seconds_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [6:0] year_offset, [10:7] month_number,
                                  // [15:11] day_of_month, [20:16] hour_of_day,
                                  // [26:21] minute_of_hour, [32:27] second_of_minute,
                                  // [39:33] zero
);
  import s2c_pkg::*;

  localparam logic [31:0] LAST_COUNT    = 32'hBC19_1380;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] DAYS_PER_QUAD = 32'd1461;

  localparam logic [8:0] DAYS_BEFORE [0:12] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  logic  adv;
  word_t first_word;
  word_t cin  [NCELL];
  word_t cout [NCELL];
  logic  vin  [NCELL];
  logic  vout [NCELL];

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [39:0] out_data_nxt;

  // Divisor fed to lane 0 of each cell, shifted down one place per cell of a split.
  function automatic logic [31:0] den0_of(input int k);
    logic [31:0] d;
    if (k < HOUR_START) begin
      d = SECS_PER_DAY << (HOUR_START - 1 - k);
    end else if (k < MIN_START) begin
      d = SECS_PER_HOUR << (MIN_START - 1 - k);
    end else begin
      d = SECS_PER_MIN << (NCELL - 1 - k);
    end
    return d;
  endfunction

  // Lane 1 only divides the day count into four-year blocks; elsewhere it idles.
  function automatic logic [31:0] den1_of(input int k);
    logic [31:0] d;
    if (k >= HOUR_START && k < MIN_START) begin
      d = DAYS_PER_QUAD << (MIN_START - 1 - k);
    end else begin
      d = 32'd0;
    end
    return d;
  endfunction

  // Day count done: split seconds of day into hours and days into four-year blocks.
  function automatic word_t remap_hour(input word_t w);
    word_t o;
    o         = w;
    o.l0.num  = w.l0.num;
    o.l0.quo  = 16'd0;
    o.l1.num  = {16'd0, w.l0.quo};
    o.l1.quo  = 16'd0;
    return o;
  endfunction

  // Hours and blocks done. Within a block the first year is the leap year (2100 is out of
  // range, so every year divisible by four here is leap).
  function automatic word_t remap_min(input word_t w);
    word_t       o;
    logic [10:0] r;
    logic [10:0] dd;
    logic [1:0]  ky;
    o  = w;
    r  = w.l1.num[10:0];
    if (r < 11'd366) begin
      ky = 2'd0;
      dd = r;
    end else if (r < 11'd731) begin
      ky = 2'd1;
      dd = r - 11'd366;
    end else if (r < 11'd1096) begin
      ky = 2'd2;
      dd = r - 11'd731;
    end else begin
      ky = 2'd3;
      dd = r - 11'd1096;
    end
    o.side.hour = w.l0.quo[4:0];
    o.side.yr   = {w.l1.quo[4:0], 2'b00} + {5'd0, ky};
    o.side.leap = (ky == 2'd0);
    o.side.yday = dd[8:0] + 9'd1;
    o.l0.num    = w.l0.num;
    o.l0.quo    = 16'd0;
    return o;
  endfunction

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    first_word          = '0;
    first_word.l0.num   = in_tdata;
    first_word.side.ovf = (in_tdata >= LAST_COUNT);
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cin[k] = first_word;
      assign vin[k] = in_tvalid;
    end else if (k == HOUR_START) begin : g_hour
      assign cin[k] = remap_hour(cout[k-1]);
      assign vin[k] = vout[k-1];
    end else if (k == MIN_START) begin : g_min
      assign cin[k] = remap_min(cout[k-1]);
      assign vin[k] = vout[k-1];
    end else begin : g_pass
      assign cin[k] = cout[k-1];
      assign vin[k] = vout[k-1];
    end

    s2c_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (vin[k]),
      .in_word  (cin[k]),
      .den0     (den0_of(k)),
      .den1     (den1_of(k)),
      .out_valid(vout[k]),
      .out_word (cout[k])
    );
  end

  // Month from the day of year; later months win, so the last threshold passed decides.
  always_comb begin
    word_t      w;
    logic [8:0] thr;
    logic [8:0] sub;
    logic [8:0] dy;
    logic [3:0] mo;
    w  = cout[NCELL-1];
    mo = 4'd1;
    for (int m = 1; m <= 12; m++) begin
      thr = DAYS_BEFORE[4'(m)] + {8'd0, w.side.leap & (m > 2)};
      if (w.side.yday > thr) begin
        mo = 4'(m);
      end
    end
    sub = DAYS_BEFORE[mo] + {8'd0, w.side.leap & (mo > 4'd2)};
    dy  = w.side.yday - sub;
    if (w.side.ovf) begin
      out_data_nxt = {7'd0, 6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 7'd0};
    end else begin
      out_data_nxt = {7'd0, w.l0.num[5:0], w.l0.quo[5:0], w.side.hour,
                      dy[4:0], mo, w.side.yr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vout[NCELL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vout[NCELL-1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while the output word is stalled");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[10:7] != 4'd0 && out_data_r[10:7] <= 4'd12 &&
                     out_data_r[15:11] != 5'd0 && out_data_r[6:0] <= 7'd99))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[20:16] <= 5'd23 && out_data_r[26:21] <= 6'd59 &&
                     out_data_r[32:27] <= 6'd59))
    else $error("time field out of range");

  a_new_word_follows_chain: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(adv) && $past(vout[NCELL-1])) |-> out_valid_r)
    else $error("word leaving the chain was lost");
`endif

endmodule

`default_nettype wire
